// ----- sv/cvr_pkg.sv -----
// ----------------------------------------------------------------------------
// cvr_pkg
// Shared types, rotation coefficients and the multiply-accumulate interface
// of the cube vertex rotator.
// ----------------------------------------------------------------------------
package cvr_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 32;
    localparam int ACC_W   = 64;
    localparam int SLOT_W  = 3;
    localparam int MASK_W  = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Matrix coefficients in signed Q2.30
    localparam coef_t COEF_ONE   = 32'sd1073741824;
    localparam coef_t COEF_COS   = 32'sd1073578288;
    localparam coef_t COEF_SIN   = 32'sd18739379;
    localparam int    COEF_SHIFT = 30;
    localparam acc_t  COEF_HALF  = 64'sd536870912;

    // Axis codes, also the bit position in the axis mask
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_DONE = 2'd3;

    typedef struct packed {
        logic   valid;
        logic   first;
        logic   last;
        coef_t  a;
        coord_t b;
    } mac_op_t;

    typedef struct packed {
        logic valid;
        acc_t sum;
    } mac_res_t;

    // Entry (row, col) of the fixed one-degree rotation about one axis
    function automatic coef_t axis_coef(logic [1:0] axis, logic [1:0] row, logic [1:0] col);
        coef_t v;
        v = '0;
        if (row == col) begin
            v = (row == axis) ? COEF_ONE : COEF_COS;
        end else if (row != axis && col != axis) begin
            case (axis)
                AXIS_X:  v = (row == 2'd2) ? COEF_SIN : -COEF_SIN;
                AXIS_Y:  v = (row == 2'd0) ? COEF_SIN : -COEF_SIN;
                AXIS_Z:  v = (row == 2'd1) ? COEF_SIN : -COEF_SIN;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

// ----- sv/cvr_ram.sv -----
// ----------------------------------------------------------------------------
// cvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/cvr_mac.sv -----
// ----------------------------------------------------------------------------
// cvr_mac
// Shared two-stage multiply-accumulate unit. A sum starts on a term marked
// first (seeded with the rounding half) and is presented after its last term.
// ----------------------------------------------------------------------------
module cvr_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  cvr_pkg::mac_op_t  op,
    output cvr_pkg::mac_res_t res
);

    import cvr_pkg::*;

    logic valid_reg;
    logic first_reg;
    logic last_reg;
    acc_t prod_reg;
    acc_t acc_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // stage 1: multiply
            valid_reg <= op.valid;
            first_reg <= op.first;
            last_reg  <= op.last;
            if (op.valid)
            begin
                prod_reg <= ACC_W'(op.a) * ACC_W'(op.b);
            end
            // stage 2: accumulate
            if (valid_reg)
            begin
                acc_reg <= first_reg ? (prod_reg + COEF_HALF) : (acc_reg + prod_reg);
            end
            done_reg <= valid_reg & last_reg;
        end
    end

    assign res.valid = done_reg;
    assign res.sum   = acc_reg;

endmodule

// ----- sv/cube_vertex_rotator_core.sv -----
// ----------------------------------------------------------------------------
// cube_vertex_rotator_core
// Busy: a load item is written straight into the store and leaves the block
//   ready. A rotate item keeps the block busy while it builds the matrix for
//   each selected axis, forms the center and transforms every vertex, and
//   longer while a finished vertex waits on a full output register; the first
//   vertex leaves only after the matrix is done.
// Throughput: set by the single shared multiply-accumulate unit, which takes
//   one term per cycle (27 per matrix product, 9 per vertex).
// Reset: asynchronous, active low; all vertices read as zero until written.
// ----------------------------------------------------------------------------
module cube_vertex_rotator_core #(
    parameter int NUM_VERTICES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  logic [2:0]             vertex_slot,
    input  cvr_pkg::coord_t        coord_x,
    input  cvr_pkg::coord_t        coord_y,
    input  cvr_pkg::coord_t        coord_z,
    input  logic [2:0]             axis_mask,
    // result items
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_slot,
    output cvr_pkg::coord_t        out_x,
    output cvr_pkg::coord_t        out_y,
    output cvr_pkg::coord_t        out_z,
    output logic                   saturated,
    output logic                   last_vertex
);

    import cvr_pkg::*;

    localparam int VIDX_W = $clog2(NUM_VERTICES);
    localparam int WORD_W = 3 * COORD_W;
    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(NUM_VERTICES - 1);
    // Center is the midpoint of vertex 0 and this vertex
    localparam logic [VIDX_W-1:0] CENTER_B = VIDX_W'(5);
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_ROTATE = 1'b1;
    localparam logic [3:0] MAT_TERMS = 4'd9;
    localparam logic [3:0] VEC_TERMS = 4'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSEL,    // pick next selected axis
        ST_MTX,     // issue terms of M * A
        ST_MWAIT,   // drain and commit new matrix
        ST_CEN_A,   // read vertex 0
        ST_CEN_B,   // read center partner
        ST_CEN_C,   // form center
        ST_VRD,     // read vertex
        ST_VDIFF,   // subtract center
        ST_VISSUE,  // issue terms of M * d
        ST_VWAIT,   // collect row sums
        ST_VEMIT    // hand vertex to output, write back
    } state_t;

    state_t            state_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [1:0]        axis_reg;
    logic [1:0]        row_reg;
    logic [1:0]        col_reg;
    logic [1:0]        k_reg;
    logic [3:0]        res_cnt_reg;
    logic [VIDX_W-1:0] vidx_reg;
    coef_t             m_reg [9];
    coef_t             t_reg [9];
    coord_t            c_reg [3];
    coord_t            d_reg [3];
    coord_t            r_reg [3];
    coord_t            hold_reg [3];
    logic              sat_reg;
    logic [NUM_VERTICES-1:0] vld_reg;
    logic              rd_vld_reg;

    logic              out_valid_reg;
    logic [2:0]        out_slot_reg;
    coord_t            out_x_reg;
    coord_t            out_y_reg;
    coord_t            out_z_reg;
    logic              out_sat_reg;
    logic              out_last_reg;

    // RAM and MAC hookup
    logic              ram_we;
    logic [VIDX_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [VIDX_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] rd_word;
    coord_t            rd_comp [3];
    mac_op_t           mac_op;
    mac_res_t          mac_res;

    logic              in_fire;
    logic              load_hit;
    logic              emit_fire;
    logic [3:0]        m_idx;
    logic signed [33:0] rnd;
    logic signed [34:0] row_sum;
    coord_t            row_val;
    logic              row_over;
    coord_t            diff_val [3];
    logic [2:0]        diff_over;

    function automatic logic over32(logic signed [34:0] v);
        return (v > 35'sd2147483647) || (v < -35'sd2147483648);
    endfunction

    function automatic coord_t clamp32(logic signed [34:0] v);
        coord_t r;
        r = v[31:0];
        if (v > 35'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    // Slots past the store are dropped
    assign load_hit  = in_fire && (kind == KIND_LOAD) && (32'(vertex_slot) < NUM_VERTICES);
    // Hand the vertex over once the output register is free
    assign emit_fire = (state_reg == ST_VEMIT) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // Vertex store: a never-written entry reads as zero via its valid bit
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_we    = load_hit || emit_fire;
        ram_waddr = load_hit ? VIDX_W'(vertex_slot) : vidx_reg;
        ram_wdata = load_hit ? {coord_z, coord_y, coord_x}
                             : {r_reg[2], r_reg[1], r_reg[0]};
        case (state_reg)
            ST_CEN_A: ram_raddr = '0;
            ST_CEN_B: ram_raddr = CENTER_B;
            default:  ram_raddr = vidx_reg;
        endcase
    end

    cvr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_word    = rd_vld_reg ? ram_rdata : '0;
    assign rd_comp[0] = rd_word[COORD_W-1:0];
    assign rd_comp[1] = rd_word[2*COORD_W-1:COORD_W];
    assign rd_comp[2] = rd_word[3*COORD_W-1:2*COORD_W];

    // ------------------------------------------------------------------
    // Shared multiply-accumulate: one term per cycle while issuing
    // ------------------------------------------------------------------
    assign m_idx = 4'(row_reg) * 4'd3 + 4'(k_reg);

    always_comb
    begin
        mac_op.valid = (state_reg == ST_MTX) || (state_reg == ST_VISSUE);
        mac_op.first = (k_reg == 2'd0);
        mac_op.last  = (k_reg == 2'd2);
        mac_op.a     = m_reg[m_idx];
        mac_op.b     = (state_reg == ST_MTX) ? axis_coef(axis_reg, k_reg, col_reg)
                                             : d_reg[k_reg];
    end

    cvr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .res   (mac_res)
    );

    // Round half up from Q30, then add the center back and clamp
    assign rnd      = 34'(mac_res.sum >>> COEF_SHIFT);
    assign row_sum  = 35'(rnd) + 35'(c_reg[res_cnt_reg[1:0]]);
    assign row_val  = clamp32(row_sum);
    assign row_over = over32(row_sum);

    // Difference to the center, clamped per component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_val[i]  = clamp32(35'(rd_comp[i]) - 35'(c_reg[i]));
            diff_over[i] = over32(35'(rd_comp[i]) - 35'(c_reg[i]));
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            axis_reg      <= AXIS_X;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            res_cnt_reg   <= '0;
            vidx_reg      <= '0;
            sat_reg       <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_sat_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= '0;
                t_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]    <= '0;
                d_reg[i]    <= '0;
                r_reg[i]    <= '0;
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end

            // Drop the output item once taken, unless a new one replaces it
            if (out_valid_reg && out_ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            // Collect finished sums in arrival order
            if (mac_res.valid)
            begin
                res_cnt_reg <= res_cnt_reg + 4'd1;
                if (state_reg == ST_MTX || state_reg == ST_MWAIT)
                begin
                    t_reg[res_cnt_reg] <= rnd[COEF_W-1:0];
                end
                else
                begin
                    r_reg[res_cnt_reg[1:0]] <= row_val;
                    sat_reg                 <= sat_reg | row_over;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && kind == KIND_ROTATE)
                    begin
                        mask_reg    <= axis_mask;
                        axis_reg    <= AXIS_X;
                        res_cnt_reg <= '0;
                        for (int i = 0; i < 9; i++)
                        begin
                            m_reg[i] <= (i % 4 == 0) ? COEF_ONE : '0;
                        end
                        state_reg <= ST_MSEL;
                    end
                end
                ST_MSEL:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    k_reg   <= '0;
                    if (axis_reg == AXIS_DONE)
                    begin
                        state_reg <= ST_CEN_A;
                    end
                    else if (mask_reg[axis_reg])
                    begin
                        state_reg <= ST_MTX;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                ST_MTX:
                begin
                    if (k_reg != 2'd2)
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (col_reg != 2'd2)
                        begin
                            col_reg <= col_reg + 2'd1;
                        end
                        else
                        begin
                            col_reg <= '0;
                            if (row_reg != 2'd2)
                            begin
                                row_reg <= row_reg + 2'd1;
                            end
                            else
                            begin
                                state_reg <= ST_MWAIT;
                            end
                        end
                    end
                end
                ST_MWAIT:
                begin
                    if (res_cnt_reg == MAT_TERMS)
                    begin
                        for (int i = 0; i < 9; i++)
                        begin
                            m_reg[i] <= t_reg[i];
                        end
                        res_cnt_reg <= '0;
                        axis_reg    <= axis_reg + 2'd1;
                        state_reg   <= ST_MSEL;
                    end
                end
                ST_CEN_A:
                begin
                    state_reg <= ST_CEN_B;
                end
                ST_CEN_B:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        hold_reg[i] <= rd_comp[i];
                    end
                    state_reg <= ST_CEN_C;
                end
                ST_CEN_C:
                begin
                    // floor of the midpoint is exact in 32 bits
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i] <= 32'((33'(hold_reg[i]) + 33'(rd_comp[i])) >>> 1);
                    end
                    vidx_reg  <= '0;
                    state_reg <= ST_VRD;
                end
                ST_VRD:
                begin
                    state_reg <= ST_VDIFF;
                end
                ST_VDIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        d_reg[i] <= diff_val[i];
                    end
                    sat_reg     <= |diff_over;
                    row_reg     <= '0;
                    k_reg       <= '0;
                    res_cnt_reg <= '0;
                    state_reg   <= ST_VISSUE;
                end
                ST_VISSUE:
                begin
                    if (k_reg != 2'd2)
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (row_reg != 2'd2)
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                        else
                        begin
                            state_reg <= ST_VWAIT;
                        end
                    end
                end
                ST_VWAIT:
                begin
                    if (res_cnt_reg == VEC_TERMS)
                    begin
                        state_reg <= ST_VEMIT;
                    end
                end
                ST_VEMIT:
                begin
                    if (emit_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= vidx_reg[2:0];
                        out_x_reg     <= r_reg[0];
                        out_y_reg     <= r_reg[1];
                        out_z_reg     <= r_reg[2];
                        out_sat_reg   <= sat_reg;
                        out_last_reg  <= (vidx_reg == LAST_IDX);
                        res_cnt_reg   <= '0;
                        if (vidx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            vidx_reg  <= vidx_reg + VIDX_W'(1);
                            state_reg <= ST_VRD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_slot    = out_slot_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign saturated   = out_sat_reg;
    assign last_vertex = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_sum_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.valid |-> (state_reg != ST_IDLE))
        else $error("sum arrived with no rotate in progress");

    a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VWAIT || state_reg == ST_VISSUE) |-> (res_cnt_reg <= VEC_TERMS))
        else $error("more row sums than rows for one vertex");

    a_rotate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_ROTATE) |=> !in_ready)
        else $error("input ready right after a rotate item");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_vertex) |-> (out_slot == LAST_IDX[2:0]))
        else $error("last vertex flagged on wrong slot");

endmodule
